### hdl/nttpm_pkg.sv
// Shared types, codes and helper functions for the NTT polynomial multiplier.
package nttpm_pkg;

  localparam int COEF_W   = 30;
  localparam int DEG_W    = 9;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int LG_W     = 4;
  localparam int MM_CNT_W = 5;
  localparam int ROOT_GEN = 3;

  localparam logic [COEF_W-1:0] RESET_PRIME = 30'd998244353;

  localparam logic [1:0] REQ_WR_FIRST  = 2'd0;
  localparam logic [1:0] REQ_WR_SECOND = 2'd1;
  localparam logic [1:0] REQ_RUN       = 2'd2;
  localparam logic [1:0] REQ_READ      = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_NOT_RUN = 2'd2;

  localparam logic [1:0] CFG_PRIME      = 2'd0;
  localparam logic [1:0] CFG_FIRST_DEG  = 2'd1;
  localparam logic [1:0] CFG_SECOND_DEG = 2'd2;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_LD_RED, S_LD_WAIT, S_RD_ADDR, S_RD_DATA, S_PAD,
    S_XF_START, S_BR_CHK, S_BR_R2, S_BR_R3, S_BR_W2, S_STG_CHK,
    S_PW_RED, S_PW_REDW, S_PW_LOOP, S_PW_MULW, S_PW_SQ, S_PW_SQW,
    S_BLK_INIT, S_BLK_CHK, S_J_CHK, S_J_R1, S_J_R2, S_J_TW, S_J_URED, S_J_UW,
    S_J_WHI, S_J_WLO, S_J_OW, S_XF_END,
    S_PM_CHK, S_PM_R, S_PM_W1, S_PM_S2, S_PM_W2,
    S_RV_CHK, S_RV_R2, S_RV_R3, S_RV_W,
    S_SC_CHK, S_SC_R, S_SC_W, S_RESP
  } state_t;

  typedef struct packed {
    logic              start;
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [COEF_W-1:0] res;
  } mm_rsp_t;

  function automatic logic [IDX_W-1:0] bit_rev(input logic [IDX_W-1:0] v,
                                               input logic [LG_W-1:0] lg);
    logic [IDX_W-1:0] r;
    for (int k = 0; k < IDX_W; k++) begin
      r[k] = v[IDX_W-1-k];
    end
    return r >> (LG_W'(IDX_W) - lg);
  endfunction

  function automatic logic [LG_W-1:0] bit_len(input logic [IDX_W-1:0] v);
    logic [LG_W-1:0] len;
    len = '0;
    for (int k = 0; k < IDX_W; k++) begin
      if (v[k]) len = LG_W'(k + 1);
    end
    return len;
  endfunction

endpackage

### hdl/ntt_polynomial_multiply.sv
// Top level: request sequencer, coefficient stores and result register.
// Coefficient write: load reduction in the 30-step modular multiplier, then the store write.
// Product read: one store read into the result register. Run: N/2*log2(N) butterflies
// per transform, three transforms, plus twiddle powers; all run on the shared multiplier.
// One request at a time; the result register lets the next request start meanwhile.
// Reset: synchronous; a clearing pass zeroes both stores first.
module ntt_polynomial_multiply #(
  parameter int MAX_LEN = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    req_type,
  input  logic [nttpm_pkg::IDX_W-1:0]   coeff_index,
  input  logic [nttpm_pkg::COEF_W-1:0]  coeff_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [nttpm_pkg::COEF_W-1:0]  product_coeff,
  output logic [1:0]                    status,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [nttpm_pkg::COEF_W-1:0]  cfg_data
);
  import nttpm_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  state_t state, state_next, ret;

  logic [COEF_W-1:0] prime;
  logic [DEG_W-1:0]  fd, sd;
  logic              product_valid;

  logic [COEF_W-1:0] mem_a [MAX_LEN];
  logic [COEF_W-1:0] mem_b [MAX_LEN];
  logic [COEF_W-1:0] rd_a, rd_b;
  logic              we_a, we_b;
  logic [AW-1:0]     waddr, raddr, clr;
  logic [COEF_W-1:0] wdata;

  logic [1:0]        q_req, pass;
  logic [IDX_W-1:0]  q_idx, rv;
  logic [COEF_W-1:0] q_val, res_coeff;
  logic [1:0]        res_status;
  logic [CNT_W-1:0]  n, i, j, blk, pbase_raw;
  logic [LG_W-1:0]   lg, s;
  logic [COEF_W-1:0] va, vb, ured, t, omg, w, pr, pbase, pe;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic [COEF_W-1:0] m_eff, cur_rd, bf_sum, bf_diff;
  logic [COEF_W:0]   bf_wide;
  logic [IDX_W-1:0]  total, br_r;
  logic [LG_W-1:0]   run_lg;
  logic [CNT_W-1:0]  run_n, half, len, lo, hi, n_minus_i;
  logic              wr_bad, rd_bad, too_long, cur_b;

  nttpm_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .m   (m_eff),
    .rsp (mm_rsp)
  );

  always_comb begin
    m_eff     = (prime < COEF_W'(3)) ? COEF_W'(3) : prime;
    total     = IDX_W'(fd) + IDX_W'(sd);
    run_lg    = bit_len(total);
    run_n     = CNT_W'(1) << run_lg;
    too_long  = 32'(run_n) > 32'(MAX_LEN);
    wr_bad    = (coeff_index > IDX_W'((req_type == REQ_WR_FIRST) ? fd : sd)) ||
                (32'(coeff_index) >= 32'(MAX_LEN));
    rd_bad    = (coeff_index > total) || (32'(coeff_index) >= 32'(MAX_LEN));
    cur_b     = (pass == 2'd1);
    cur_rd    = cur_b ? rd_b : rd_a;
    br_r      = bit_rev(i[IDX_W-1:0], lg);
    half      = CNT_W'(1) << (s - LG_W'(1));
    len       = CNT_W'(1) << s;
    lo        = blk + j;
    hi        = blk + j + half;
    n_minus_i = n - i;
    bf_wide   = {1'b0, ured} + {1'b0, t};
    bf_sum    = (bf_wide >= {1'b0, m_eff}) ? COEF_W'(bf_wide - {1'b0, m_eff})
                                          : bf_wide[COEF_W-1:0];
    bf_diff   = (ured >= t) ? ured - t : ured + (m_eff - t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= RESET_PRIME;
      fd    <= '0;
      sd    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PRIME:      prime <= cfg_data;
        CFG_FIRST_DEG:  fd    <= cfg_data[DEG_W-1:0];
        CFG_SECOND_DEG: sd    <= cfg_data[DEG_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) mem_a[waddr] <= wdata;
    rd_a <= mem_a[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[waddr] <= wdata;
    rd_b <= mem_b[raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:      if (clr == AW'(MAX_LEN - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (req_valid) begin
          case (req_type)
            REQ_WR_FIRST, REQ_WR_SECOND: state_next = wr_bad ? S_RESP : S_LD_RED;
            REQ_RUN:                     state_next = too_long ? S_RESP : S_PAD;
            default: state_next = (!product_valid || rd_bad) ? S_RESP : S_RD_ADDR;
          endcase
        end
      end
      S_LD_RED:   state_next = S_LD_WAIT;
      S_LD_WAIT:  if (mm_rsp.done) state_next = S_RESP;
      S_RD_ADDR:  state_next = S_RD_DATA;
      S_RD_DATA:  state_next = S_RESP;
      S_PAD:      if (i == n - CNT_W'(1)) state_next = S_XF_START;
      S_XF_START: state_next = S_BR_CHK;
      S_BR_CHK: begin
        if (i == n) state_next = S_STG_CHK;
        else if (i < CNT_W'(br_r)) state_next = S_BR_R2;
      end
      S_BR_R2:    state_next = S_BR_R3;
      S_BR_R3:    state_next = S_BR_W2;
      S_BR_W2:    state_next = S_BR_CHK;
      S_STG_CHK:  state_next = (s > lg) ? S_XF_END : S_PW_RED;
      S_PW_RED:   state_next = S_PW_REDW;
      S_PW_REDW:  if (mm_rsp.done) state_next = S_PW_LOOP;
      S_PW_LOOP: begin
        if (pe == '0) state_next = ret;
        else if (pe[0]) state_next = S_PW_MULW;
        else state_next = S_PW_SQ;
      end
      S_PW_MULW:  if (mm_rsp.done) state_next = S_PW_SQ;
      S_PW_SQ:    state_next = S_PW_SQW;
      S_PW_SQW:   if (mm_rsp.done) state_next = S_PW_LOOP;
      S_BLK_INIT: state_next = S_BLK_CHK;
      S_BLK_CHK:  state_next = (blk >= n) ? S_STG_CHK : S_J_CHK;
      S_J_CHK:    state_next = (j == half) ? S_BLK_CHK : S_J_R1;
      S_J_R1:     state_next = S_J_R2;
      S_J_R2:     state_next = S_J_TW;
      S_J_TW:     if (mm_rsp.done) state_next = S_J_URED;
      S_J_URED:   state_next = S_J_UW;
      S_J_UW:     if (mm_rsp.done) state_next = S_J_WHI;
      S_J_WHI:    state_next = S_J_WLO;
      S_J_WLO:    state_next = S_J_OW;
      S_J_OW:     if (mm_rsp.done) state_next = S_J_CHK;
      S_XF_END: begin
        case (pass)
          2'd0:    state_next = S_XF_START;
          2'd1:    state_next = S_PM_CHK;
          default: state_next = S_RV_CHK;
        endcase
      end
      S_PM_CHK:   state_next = (i == n) ? S_XF_START : S_PM_R;
      S_PM_R:     state_next = S_PM_W1;
      S_PM_W1:    if (mm_rsp.done) state_next = S_PM_S2;
      S_PM_S2:    state_next = S_PM_W2;
      S_PM_W2:    if (mm_rsp.done) state_next = S_PM_CHK;
      S_RV_CHK:   state_next = (i < n_minus_i) ? S_RV_R2 : S_PW_RED;
      S_RV_R2:    state_next = S_RV_R3;
      S_RV_R3:    state_next = S_RV_W;
      S_RV_W:     state_next = S_RV_CHK;
      S_SC_CHK:   state_next = (i == n) ? S_RESP : S_SC_R;
      S_SC_R:     state_next = S_SC_W;
      S_SC_W:     if (mm_rsp.done) state_next = S_SC_CHK;
      S_RESP:     if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory ports, multiplier requests and input stall
  always_comb begin
    req_stall    = 1'b1;
    we_a         = 1'b0;
    we_b         = 1'b0;
    waddr        = '0;
    wdata        = '0;
    raddr        = '0;
    mm_req.start = 1'b0;
    mm_req.a     = '0;
    mm_req.b     = '0;
    case (state)
      S_CLR: begin
        we_a  = 1'b1;
        we_b  = 1'b1;
        waddr = clr;
      end
      S_IDLE: req_stall = 1'b0;
      S_LD_RED: begin
        mm_req.start = 1'b1;
        mm_req.a     = COEF_W'(1);
        mm_req.b     = q_val;
      end
      S_LD_WAIT: begin
        we_a  = mm_rsp.done && (q_req == REQ_WR_FIRST);
        we_b  = mm_rsp.done && (q_req == REQ_WR_SECOND);
        waddr = AW'(q_idx);
        wdata = mm_rsp.res;
      end
      S_RD_ADDR: raddr = AW'(q_idx);
      S_PAD: begin
        we_a  = i > CNT_W'(fd);
        we_b  = i > CNT_W'(sd);
        waddr = AW'(i);
      end
      S_BR_CHK: raddr = AW'(i);
      S_BR_R2:  raddr = AW'(rv);
      S_BR_R3: begin
        we_a  = !cur_b;
        we_b  = cur_b;
        waddr = AW'(i);
        wdata = cur_rd;
      end
      S_BR_W2: begin
        we_a  = !cur_b;
        we_b  = cur_b;
        waddr = AW'(rv);
        wdata = va;
      end
      S_PW_RED: begin
        mm_req.start = 1'b1;
        mm_req.a     = COEF_W'(1);
        mm_req.b     = COEF_W'(pbase_raw);
      end
      S_PW_LOOP: begin
        mm_req.start = (pe != '0) && pe[0];
        mm_req.a     = pr;
        mm_req.b     = pbase;
      end
      S_PW_SQ: begin
        mm_req.start = 1'b1;
        mm_req.a     = pbase;
        mm_req.b     = pbase;
      end
      S_J_CHK: raddr = AW'(hi);
      S_J_R1: begin
        raddr        = AW'(lo);
        mm_req.start = 1'b1;
        mm_req.a     = omg;
        mm_req.b     = cur_rd;
      end
      S_J_URED: begin
        mm_req.start = 1'b1;
        mm_req.a     = COEF_W'(1);
        mm_req.b     = va;
      end
      S_J_WHI: begin
        we_a  = !cur_b;
        we_b  = cur_b;
        waddr = AW'(hi);
        wdata = bf_diff;
      end
      S_J_WLO: begin
        we_a         = !cur_b;
        we_b         = cur_b;
        waddr        = AW'(lo);
        wdata        = bf_sum;
        mm_req.start = 1'b1;
        mm_req.a     = omg;
        mm_req.b     = w;
      end
      S_PM_CHK: raddr = AW'(i);
      S_PM_R: begin
        mm_req.start = 1'b1;
        mm_req.a     = COEF_W'(1);
        mm_req.b     = rd_a;
      end
      S_PM_S2: begin
        mm_req.start = 1'b1;
        mm_req.a     = ured;
        mm_req.b     = vb;
      end
      S_PM_W2, S_SC_W: begin
        we_a  = mm_rsp.done;
        waddr = AW'(i);
        wdata = mm_rsp.res;
      end
      S_RV_CHK: raddr = AW'(i);
      S_RV_R2:  raddr = AW'(n_minus_i);
      S_RV_R3: begin
        we_a  = 1'b1;
        waddr = AW'(i);
        wdata = rd_a;
      end
      S_RV_W: begin
        we_a  = 1'b1;
        waddr = AW'(n_minus_i);
        wdata = va;
      end
      S_SC_CHK: raddr = AW'(i);
      S_SC_R: begin
        mm_req.start = 1'b1;
        mm_req.a     = pr;
        mm_req.b     = rd_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      ret           <= S_IDLE;
      clr           <= '0;
      product_valid <= 1'b0;
      rsp_valid     <= 1'b0;
      pass          <= '0;
      i             <= '0;
    end else begin
      state <= state_next;
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      case (state)
        S_CLR: clr <= clr + AW'(1);
        S_IDLE: begin
          if (req_valid) begin
            q_req      <= req_type;
            q_idx      <= coeff_index;
            q_val      <= coeff_value;
            res_coeff  <= '0;
            res_status <= STAT_OK;
            n          <= run_n;
            lg         <= run_lg;
            i          <= '0;
            case (req_type)
              REQ_WR_FIRST, REQ_WR_SECOND: if (wr_bad) res_status <= STAT_RANGE;
              REQ_RUN:                     if (too_long) res_status <= STAT_RANGE;
              default: begin
                if (!product_valid) res_status <= STAT_NOT_RUN;
                else if (rd_bad) res_status <= STAT_RANGE;
              end
            endcase
          end
        end
        S_LD_WAIT: if (mm_rsp.done) product_valid <= 1'b0;
        S_RD_DATA: res_coeff <= rd_a;
        S_PAD: begin
          i    <= i + CNT_W'(1);
          pass <= '0;
        end
        S_XF_START: begin
          i <= '0;
          s <= LG_W'(1);
        end
        S_BR_CHK: begin
          rv <= br_r;
          if (i != n && !(i < CNT_W'(br_r))) i <= i + CNT_W'(1);
        end
        S_BR_R2: va <= cur_rd;
        S_BR_W2: i <= i + CNT_W'(1);
        S_STG_CHK: begin
          // twiddle root for this stage: 3^((p-1)/len)
          pbase_raw <= CNT_W'(ROOT_GEN);
          pe        <= (m_eff - COEF_W'(1)) >> s;
          ret       <= S_BLK_INIT;
        end
        S_PW_REDW: begin
          if (mm_rsp.done) begin
            pbase <= mm_rsp.res;
            pr    <= COEF_W'(1);
          end
        end
        S_PW_MULW: if (mm_rsp.done) pr <= mm_rsp.res;
        S_PW_SQW: begin
          if (mm_rsp.done) begin
            pbase <= mm_rsp.res;
            pe    <= pe >> 1;
          end
        end
        S_BLK_INIT: begin
          w   <= pr;
          blk <= '0;
        end
        S_BLK_CHK: begin
          if (blk >= n) begin
            s <= s + LG_W'(1);
          end else begin
            omg <= COEF_W'(1);
            j   <= '0;
          end
        end
        S_J_CHK: if (j == half) blk <= blk + len;
        S_J_R2:  va <= cur_rd;
        S_J_TW:  if (mm_rsp.done) t <= mm_rsp.res;
        S_J_UW:  if (mm_rsp.done) ured <= mm_rsp.res;
        S_J_OW: begin
          if (mm_rsp.done) begin
            omg <= mm_rsp.res;
            j   <= j + CNT_W'(1);
          end
        end
        S_XF_END: begin
          pass <= pass + 2'd1;
          i    <= (pass == 2'd2) ? CNT_W'(1) : '0;
        end
        S_PM_R:  vb <= rd_b;
        S_PM_W1: if (mm_rsp.done) ured <= mm_rsp.res;
        S_PM_W2: if (mm_rsp.done) i <= i + CNT_W'(1);
        S_RV_CHK: begin
          if (!(i < n_minus_i)) begin
            // scale factor N^(p-2)
            pbase_raw <= n;
            pe        <= m_eff - COEF_W'(2);
            ret       <= S_SC_CHK;
            i         <= '0;
          end
        end
        S_RV_R2: va <= rd_a;
        S_RV_W:  i <= i + CNT_W'(1);
        S_SC_CHK: if (i == n) product_valid <= 1'b1;
        S_SC_W:  if (mm_rsp.done) i <= i + CNT_W'(1);
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid     <= 1'b1;
            product_coeff <= res_coeff;
            status        <= res_status;
          end
        end
        default: ;
      endcase
    end
  end

  a_mm_no_overlap: assert property (@(posedge clk) disable iff (rst)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  a_read_needs_product: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_DATA) |-> product_valid)
    else $error("product read without a finished run");

  a_valid_rises_at_end: assert property (@(posedge clk) disable iff (rst)
    $rose(product_valid) |-> ($past(state) == S_SC_CHK))
    else $error("product marked valid outside the scaling pass");

  a_stall_outside_idle: assert property (@(posedge clk) disable iff (rst)
    (mm_rsp.busy || we_a) |-> req_stall)
    else $error("request taken while the sequencer is working");

endmodule

### hdl/nttpm_modmul.sv
// Shared bit-serial modular multiplier: a*b mod m, one bit of b per cycle.
module nttpm_modmul (
  input  logic                    clk,
  input  logic                    rst,
  input  nttpm_pkg::mm_req_t      req,
  input  logic [nttpm_pkg::COEF_W-1:0] m,
  output nttpm_pkg::mm_rsp_t      rsp
);
  import nttpm_pkg::*;

  logic [COEF_W-1:0]   acc;
  logic [COEF_W-1:0]   a_q;
  logic [COEF_W-1:0]   b_q;
  logic [COEF_W-1:0]   m_q;
  logic [MM_CNT_W-1:0] cnt;
  logic                busy;
  logic                done;

  logic [COEF_W:0] dbl;
  logic [COEF_W:0] dbl_red;
  logic [COEF_W:0] sum;
  logic [COEF_W-1:0] acc_next;

  // acc stays below m; double, fold, add a, fold
  always_comb begin
    dbl      = {acc, 1'b0};
    dbl_red  = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum      = dbl_red + (b_q[COEF_W-1] ? {1'b0, a_q} : '0);
    acc_next = (sum >= {1'b0, m_q}) ? COEF_W'(sum - {1'b0, m_q}) : sum[COEF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= MM_CNT_W'(COEF_W);
        acc  <= '0;
        a_q  <= req.a;
        b_q  <= req.b;
        m_q  <= m;
      end else if (busy) begin
        acc <= acc_next;
        b_q <= b_q << 1;
        cnt <= cnt - MM_CNT_W'(1);
        if (cnt == MM_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.res  = acc;

endmodule

### tb/ntt_polynomial_multiply_check.sv
// Checker for the NTT polynomial multiplier: predicts each response and compares.
`timescale 1ns / 100ps
module ntt_polynomial_multiply_check
  import nttpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic [1:0]        req_type,
  input  logic [IDX_W-1:0]  coeff_index,
  input  logic [COEF_W-1:0] coeff_value,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  logic [COEF_W-1:0] product_coeff,
  input  logic [1:0]        status,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data,
  output int                failures,
  output int                pending
);

  localparam int STORE_LEN = 1024;

  logic [COEF_W-1:0] modulus;
  logic [DEG_W-1:0]  deg_a;
  logic [DEG_W-1:0]  deg_b;
  bit [31:0]         poly_a [STORE_LEN];
  bit [31:0]         poly_b [STORE_LEN];
  bit [31:0]         work [STORE_LEN];
  bit                product_ready;

  logic [COEF_W-1:0] coeff_due [$];
  logic [1:0]        status_due [$];

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = r * b % m;
      b = b * b % m;
      e = e >> 1;
    end
    return r;
  endfunction

  // In-place forward transform of the work array.
  function automatic void transform_work(int n, int lg, longint unsigned m);
    int r, len, half, blk;
    bit [31:0] t;
    longint unsigned w, omg, u, tw;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int j = 0; j < lg; j++)
        if ((i >> j) & 1) r |= 1 << (lg - j - 1);
      if (i < r) begin
        t = work[i];
        work[i] = work[r];
        work[r] = t;
      end
    end
    for (len = 2; len <= n; len = len << 1) begin
      half = len / 2;
      w = pow_mod(longint'(ROOT_GEN), (m - 1) / longint'(len), m);
      for (blk = 0; blk < n; blk += len) begin
        omg = 1 % m;
        for (int j = 0; j < half; j++) begin
          u  = work[blk + j];
          tw = omg * work[blk + j + half] % m;
          work[blk + j + half] = 32'((u + m - tw) % m);
          work[blk + j]        = 32'((u + tw) % m);
          omg = omg * w % m;
        end
      end
    end
  endfunction

  function automatic void multiply_operands(int n, int lg, longint unsigned m);
    longint unsigned inv;
    bit [31:0] t;
    for (int i = deg_a + 1; i < n; i++) poly_a[i] = 0;
    for (int i = deg_b + 1; i < n; i++) poly_b[i] = 0;
    for (int i = 0; i < n; i++) work[i] = poly_a[i];
    transform_work(n, lg, m);
    for (int i = 0; i < n; i++) poly_a[i] = work[i];
    for (int i = 0; i < n; i++) work[i] = poly_b[i];
    transform_work(n, lg, m);
    for (int i = 0; i < n; i++) poly_b[i] = work[i];
    for (int i = 0; i < n; i++)
      work[i] = 32'(longint'(poly_a[i]) * longint'(poly_b[i]) % m);
    transform_work(n, lg, m);
    for (int i = 1; i < n - i; i++) begin
      t = work[i];
      work[i] = work[n - i];
      work[n - i] = t;
    end
    inv = pow_mod(longint'(n), m - 2, m);
    for (int i = 0; i < n; i++) poly_a[i] = 32'(longint'(work[i]) * inv % m);
  endfunction

  function automatic void predict_request(logic [1:0] kind, logic [IDX_W-1:0] idx,
                                          logic [COEF_W-1:0] val);
    longint unsigned m;
    int total, n, lg;
    logic [COEF_W-1:0] coeff;
    logic [1:0] stat;
    m = (modulus < 3) ? 3 : longint'(modulus);
    total = deg_a + deg_b;
    coeff = '0;
    stat = STAT_OK;
    case (kind)
      REQ_WR_FIRST, REQ_WR_SECOND: begin
        if (idx > ((kind == REQ_WR_FIRST) ? deg_a : deg_b) || idx >= STORE_LEN) begin
          stat = STAT_RANGE;
        end else begin
          if (kind == REQ_WR_FIRST) poly_a[idx] = 32'(longint'(val) % m);
          else poly_b[idx] = 32'(longint'(val) % m);
          product_ready = 1'b0;
        end
      end
      REQ_RUN: begin
        n = 1;
        lg = 0;
        while (n <= total) begin
          n = n << 1;
          lg++;
        end
        if (n > STORE_LEN) begin
          stat = STAT_RANGE;
        end else begin
          multiply_operands(n, lg, m);
          product_ready = 1'b1;
        end
      end
      default: begin
        if (!product_ready) stat = STAT_NOT_RUN;
        else if (idx > total || idx >= STORE_LEN) stat = STAT_RANGE;
        else coeff = poly_a[idx][COEF_W-1:0];
      end
    endcase
    coeff_due.push_back(coeff);
    status_due.push_back(stat);
  endfunction

  initial failures = 0;

  always @(posedge clk) begin
    if (rst) begin
      modulus <= RESET_PRIME;
      deg_a <= '0;
      deg_b <= '0;
      for (int i = 0; i < STORE_LEN; i++) begin
        poly_a[i] = 0;
        poly_b[i] = 0;
      end
      product_ready = 1'b0;
      coeff_due.delete();
      status_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PRIME:      modulus <= cfg_data;
          CFG_FIRST_DEG:  deg_a <= cfg_data[DEG_W-1:0];
          CFG_SECOND_DEG: deg_b <= cfg_data[DEG_W-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (coeff_due.size() == 0) begin
          $display("%0t: response with nothing expected (coeff %0d status %0d)",
                   $time, product_coeff, status);
          failures++;
        end else begin
          if (product_coeff !== coeff_due[0]) begin
            $display("%0t: product_coeff expected %0d actual %0d", $time,
                     coeff_due[0], product_coeff);
            failures++;
          end
          if (status !== status_due[0]) begin
            $display("%0t: status expected %0d actual %0d", $time, status_due[0], status);
            failures++;
          end
          void'(coeff_due.pop_front());
          void'(status_due.pop_front());
        end
      end
      if (req_valid && !req_stall) predict_request(req_type, coeff_index, coeff_value);
    end
    pending = coeff_due.size();
  end

endmodule

### tb/ntt_polynomial_multiply_test.sv
// Stimulus and verdict for the NTT polynomial multiplier.
`timescale 1ns / 100ps
module ntt_polynomial_multiply_test;
  import nttpm_pkg::*;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic [1:0]        req_type;
  logic [IDX_W-1:0]  coeff_index;
  logic [COEF_W-1:0] coeff_value;
  logic              rsp_valid;
  logic              rsp_stall;
  logic [COEF_W-1:0] product_coeff;
  logic [1:0]        status;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [COEF_W-1:0] cfg_data;
  int                failures;
  int                pending;

  int items;
  bit quiet;
  bit hold_off;
  logic [COEF_W-1:0] primes [8] = '{30'd998244353, 30'd469762049, 30'd1004535809, 30'd3,
                                    30'd17, 30'd97, 30'd1073741823, 30'd0};

  ntt_polynomial_multiply i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .coeff_index(coeff_index), .coeff_value(coeff_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .product_coeff(product_coeff), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ntt_polynomial_multiply_check i_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .coeff_index(coeff_index), .coeff_value(coeff_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .product_coeff(product_coeff), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [COEF_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return COEF_W'($urandom_range(0, 20));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp_stall <= 1'b1;
        repeat (400) @(negedge clk);
        rsp_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Entered and left at a falling edge; valid stays high between back-to-back transfers.
  task automatic send(logic [1:0] kind, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    coeff_index <= idx;
    coeff_value <= val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    items++;
  endtask

  // Hold the request side until every response is in, then let the block settle.
  task automatic drain();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_regs(logic [COEF_W-1:0] p, logic [DEG_W-1:0] da, logic [DEG_W-1:0] db);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PRIME;
    cfg_data <= p;
    @(negedge clk);
    cfg_index <= CFG_FIRST_DEG;
    cfg_data <= (COEF_W'($urandom) & ~COEF_W'(9'h1FF)) | COEF_W'(da);
    @(negedge clk);
    cfg_index <= CFG_SECOND_DEG;
    cfg_data <= (COEF_W'($urandom) & ~COEF_W'(9'h1FF)) | COEF_W'(db);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic noise();
    if ($urandom_range(0, 7) == 0)
      send(2'($urandom_range(0, 3)), IDX_W'($urandom), pick_value());
  endtask

  task automatic run_phase(logic [COEF_W-1:0] p, int da, int db, bit big);
    int total;
    total = da + db;
    drain();
    write_regs(p, DEG_W'(da), DEG_W'(db));
    if (big) begin
      repeat (8) send(REQ_WR_FIRST, IDX_W'($urandom_range(0, da)), pick_value());
      repeat (8) send(REQ_WR_SECOND, IDX_W'($urandom_range(0, db)), pick_value());
    end else begin
      for (int i = 0; i <= da; i++) begin
        noise();
        send(REQ_WR_FIRST, IDX_W'(i), pick_value());
      end
      for (int i = 0; i <= db; i++) begin
        noise();
        send(REQ_WR_SECOND, IDX_W'(i), pick_value());
      end
    end
    // Now and then leave out the run to exercise a broken sequence.
    if ($urandom_range(0, 9) != 0) send(REQ_RUN, IDX_W'($urandom), pick_value());
    if (big) begin
      repeat (24) send(REQ_READ, IDX_W'($urandom), pick_value());
    end else begin
      for (int i = 0; i <= total + 2; i++) begin
        noise();
        send(REQ_READ, IDX_W'(i), pick_value());
      end
    end
  endtask

  initial begin
    items = 0;
    quiet = 1'b0;
    hold_off = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = REQ_WR_FIRST;
    coeff_index = '0;
    coeff_value = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_PRIME;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset registers, single-coefficient operands.
    send(REQ_READ, '0, '0);
    send(REQ_WR_FIRST, '0, '1);
    send(REQ_WR_SECOND, '0, 30'd12345);
    send(REQ_WR_FIRST, 10'd1, 30'd7);
    send(REQ_WR_SECOND, '1, 30'd7);
    send(REQ_RUN, '1, '1);
    send(REQ_READ, '0, '1);
    send(REQ_READ, 10'd1, '0);
    send(REQ_READ, '1, '0);
    send(REQ_WR_FIRST, '0, 30'd998244353);
    send(REQ_READ, '0, '0);
    send(REQ_RUN, '0, '0);
    send(REQ_READ, '0, '0);

    run_phase(30'd2, 3, 2, 1'b0);
    hold_off = 1'b1;
    run_phase(30'd1073741823, 5, 4, 1'b0);
    run_phase(30'd998244353, 511, 511, 1'b1);
    run_phase(30'd469762049, 0, 0, 1'b0);
    while (items < 750) begin
      if (items > 650) quiet = 1'b1;
      run_phase(primes[$urandom_range(0, 7)], $urandom_range(0, 12),
                $urandom_range(0, 12), 1'b0);
    end
    drain();
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
